@@ rtl/bfa_pkg.sv @@
// Shared types, constants and helpers for the buddy frame allocator.
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int FRAME_CNT = 4096;
    localparam int MAX_ORD   = 11;
    localparam int IDX_W     = 12;
    localparam int LINK_W    = 13;
    localparam int ORD_W     = 4;
    localparam int PFN_W     = 20;
    localparam int CNT_W     = 13;
    localparam int GFR_W     = 12;
    localparam int NORD      = MAX_ORD + 1;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(FRAME_CNT);
    localparam logic [ORD_W-1:0]  ORD_TOP   = ORD_W'(MAX_ORD);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(1 << MAX_ORD);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_START = 1'b0;
    localparam logic REG_ZONE  = 1'b1;

    typedef struct packed {
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
        logic [ORD_W-1:0]  ord;
        logic              free;
    } t_rec;

    typedef enum logic [4:0] {
        S_CLR, S_BLD, S_BLD2, S_IDLE, S_DEC, S_ASRCH, S_ULRD,
        S_U1, S_U2, S_U3, S_SPLIT, S_LH1, S_LH2, S_FCHK, S_M0, S_M1, S_DONE
    } t_state;

    // Smallest order whose block holds the count; count in 1..2^MAX_ORD.
    function automatic logic [ORD_W-1:0] ceil_ord(input logic [CNT_W-1:0] c);
        logic [ORD_W-1:0] o;
        o = ORD_TOP;
        for (int k = MAX_ORD; k >= 0; k--) begin
            if ((CNT_W'(1) << k) >= c) o = ORD_W'(k);
        end
        return o;
    endfunction

    // Largest order whose block fits in the count, capped at MAX_ORD.
    function automatic logic [ORD_W-1:0] floor_ord(input logic [CNT_W-1:0] c);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int k = 0; k <= MAX_ORD; k++) begin
            if (c >= (CNT_W'(1) << k)) o = ORD_W'(k);
        end
        return o;
    endfunction

endpackage

@@ rtl/buddy_frame_allocator_unit.sv @@
// Buddy allocator over a frame zone, free lists linked through a record memory.
`timescale 1ns / 1ps
// Usage:
//   Slave stream s_*: one request word per transfer. s_tuser is the operation
//   (0 allocate, 1 free); s_tdata holds frame_count then block_pfn.
//   Master stream m_*: one result word per request. m_tuser is the status;
//   m_tdata holds granted_pfn then granted_frames.
//   Config channel i_cfg_*: index 0 zone base frame, index 1 zone_frames; taken
//   only while idle, and each write rebuilds the free lists. s_tready stays low
//   while a config write is offered.
// Sequencing: a request runs through a sequencer around one record memory with
//   registered reads. Allocate searches the orders, unlinks the block found and
//   links back each split half; free checks the block, then reads and merges each
//   free buddy and links the result; a rejected request ends with no list change.
//   One request is in flight at a time.
// Reset and config writes: a clearing pass sweeps all 4096 records, one per
//   cycle, then the zone is cut into blocks, each written and then linked to its
//   list; no request is taken during that time.
// Stall: a result waits in the output register until m_tready; the next
//   request is taken once that register is empty.
module buddy_frame_allocator_unit
    import bfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [12:0] frame_count, [32:13] block_pfn, rest zero
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [19:0] granted_pfn, [31:20] granted_frames
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    t_rec r_mem [FRAME_CNT];

    t_state r_state, n_state;
    logic [PFN_W-1:0]  r_start;
    logic [CNT_W-1:0]  r_zone_frames;
    logic [LINK_W-1:0] r_head [NORD];
    logic [LINK_W-1:0] r_tail [NORD];
    logic              r_op;
    logic [CNT_W-1:0]  r_count;
    logic [PFN_W-1:0]  r_pfn;
    logic [ORD_W-1:0]  r_ord, r_oi, r_uord, r_lh_ord;
    logic [IDX_W-1:0]  r_idx, r_bidx, r_lh_idx;
    logic [LINK_W-1:0] r_p, r_n, r_h;
    logic [CNT_W-1:0]  r_left, r_cnt;
    logic [1:0]        r_status;
    logic [PFN_W-1:0]  r_gpfn;
    logic [GFR_W-1:0]  r_gfr;
    logic              r_ovalid;
    t_rec              r_rd;

    // memory port controls
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              we_prev, we_next, we_ord, we_free;
    logic [IDX_W-1:0]  wr_addr;
    t_rec              wr_rec;

    logic [CNT_W-1:0]  zone, cnt1, bsz, buddy, dec_size, bld_size;
    logic [ORD_W-1:0]  dec_ord, bld_ord;
    logic [PFN_W-1:0]  dec_idx;
    logic              dec_big, dec_bad, m0_ok, m1_ok, ul_skip;
    logic              in_acc, cfg_acc;

    assign zone     = (r_zone_frames > CNT_W'(FRAME_CNT)) ? CNT_W'(FRAME_CNT) : r_zone_frames;
    assign cnt1     = (r_count == '0) ? CNT_W'(1) : r_count;
    assign dec_big  = cnt1 > CNT_LIMIT;
    assign dec_ord  = ceil_ord(cnt1);
    assign dec_size = CNT_W'(1) << dec_ord;
    assign dec_idx  = r_pfn - r_start;
    assign dec_bad  = (dec_idx >= PFN_W'(zone)) || (dec_size > (zone - dec_idx[CNT_W-1:0]))
                    || ((dec_idx[IDX_W-1:0] & (dec_size[IDX_W-1:0] - IDX_W'(1))) != '0);
    assign bld_ord  = floor_ord(r_left);
    assign bld_size = CNT_W'(1) << bld_ord;
    assign bsz      = CNT_W'(1) << r_ord;
    assign buddy    = {1'b0, r_idx} ^ bsz;
    assign m0_ok    = (r_ord < ORD_TOP) && (buddy < zone) && !(bsz > (zone - buddy));
    assign m1_ok    = r_rd.free && (r_rd.ord == r_ord);
    assign ul_skip  = r_uord > ORD_TOP;

    assign s_tready    = (r_state == S_IDLE) && !r_ovalid && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = s_tvalid && s_tready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign m_tvalid    = r_ovalid;
    assign m_tuser     = r_status;
    assign m_tdata     = {r_gfr, r_gpfn};

    // record memory: field write enables, registered read
    always_ff @(posedge i_clk) begin
        if (we_prev) r_mem[wr_addr].prev <= wr_rec.prev;
        if (we_next) r_mem[wr_addr].next <= wr_rec.next;
        if (we_ord)  r_mem[wr_addr].ord  <= wr_rec.ord;
        if (we_free) r_mem[wr_addr].free <= wr_rec.free;
        if (rd_en)   r_rd <= r_mem[rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_cnt == CNT_W'(FRAME_CNT - 1)) n_state = S_BLD;
            S_BLD:   n_state = (r_left == '0) ? S_IDLE : S_BLD2;
            S_BLD2:  n_state = S_BLD;
            S_IDLE: begin
                if (cfg_acc)     n_state = S_CLR;
                else if (in_acc) n_state = S_DEC;
            end
            S_DEC: begin
                if (dec_big)               n_state = S_DONE;
                else if (r_op == OP_ALLOC) n_state = S_ASRCH;
                else if (dec_bad)          n_state = S_DONE;
                else                       n_state = S_FCHK;
            end
            S_ASRCH: begin
                if (r_head[r_oi] != LINK_NONE) n_state = S_ULRD;
                else if (r_oi == ORD_TOP)      n_state = S_DONE;
            end
            S_ULRD:  n_state = S_U1;
            S_U1:    n_state = ul_skip ? ((r_op == OP_ALLOC) ? S_SPLIT : S_M0) : S_U2;
            S_U2:    n_state = S_U3;
            S_U3:    n_state = (r_op == OP_ALLOC) ? S_SPLIT : S_M0;
            S_SPLIT: n_state = (r_oi > r_ord) ? S_LH1 : S_DONE;
            S_LH1:   n_state = S_LH2;
            S_LH2:   n_state = (r_op == OP_ALLOC) ? S_SPLIT : S_DONE;
            S_FCHK:  n_state = r_rd.free ? S_DONE : S_M0;
            S_M0:    n_state = m0_ok ? S_M1 : S_LH1;
            S_M1:    n_state = m1_ok ? S_U1 : S_LH1;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port outputs
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        we_prev = 1'b0;
        we_next = 1'b0;
        we_ord  = 1'b0;
        we_free = 1'b0;
        wr_addr = r_idx;
        wr_rec  = '{prev: LINK_NONE, next: LINK_NONE, ord: '0, free: 1'b0};
        unique case (r_state)
            S_CLR: begin
                wr_addr = r_cnt[IDX_W-1:0];
                {we_prev, we_next, we_ord, we_free} = 4'b1111;
            end
            S_BLD: if (r_left != '0) begin
                wr_addr = r_idx;
                wr_rec  = '{prev: r_tail[bld_ord], next: LINK_NONE, ord: bld_ord, free: 1'b1};
                {we_prev, we_next, we_ord, we_free} = 4'b1111;
            end
            S_BLD2: begin
                wr_addr     = r_h[IDX_W-1:0];
                wr_rec.next = {1'b0, r_lh_idx};
                we_next     = r_h != LINK_NONE;
            end
            S_DEC: begin
                rd_en   = 1'b1;
                rd_addr = dec_idx[IDX_W-1:0];
            end
            S_ASRCH: begin
                rd_en   = 1'b1;
                rd_addr = r_head[r_oi][IDX_W-1:0];
            end
            S_U1: begin
                wr_addr     = r_p[IDX_W-1:0];
                wr_rec.next = r_n;
                we_next     = !ul_skip && (r_p != LINK_NONE);
            end
            S_U2: begin
                wr_addr     = r_n[IDX_W-1:0];
                wr_rec.prev = r_p;
                we_prev     = r_n != LINK_NONE;
            end
            S_U3: begin
                wr_addr = r_bidx;
                {we_prev, we_next, we_free} = 3'b111;
            end
            S_LH1: begin
                wr_addr = r_lh_idx;
                wr_rec  = '{prev: LINK_NONE, next: r_head[r_lh_ord], ord: r_lh_ord, free: 1'b1};
                {we_prev, we_next, we_ord, we_free} = 4'b1111;
            end
            S_LH2: begin
                wr_addr     = r_h[IDX_W-1:0];
                wr_rec.prev = {1'b0, r_lh_idx};
                we_prev     = r_h != LINK_NONE;
            end
            S_M0: begin
                rd_en   = m0_ok;
                rd_addr = buddy[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_cnt         <= '0;
            r_start       <= '0;
            r_zone_frames <= CNT_W'(FRAME_CNT);
            r_ovalid      <= 1'b0;
            for (int k = 0; k < NORD; k++) begin
                r_head[k] <= LINK_NONE;
                r_tail[k] <= LINK_NONE;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && m_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_cnt  <= r_cnt + CNT_W'(1);
                    r_left <= zone;
                    r_idx  <= '0;
                end
                S_BLD: if (r_left != '0) begin
                    r_h      <= r_tail[bld_ord];
                    r_lh_idx <= r_idx;
                    r_tail[bld_ord] <= {1'b0, r_idx};
                    if (r_tail[bld_ord] == LINK_NONE) r_head[bld_ord] <= {1'b0, r_idx};
                    r_idx  <= r_idx + bld_size[IDX_W-1:0];
                    r_left <= r_left - bld_size;
                end
                S_IDLE: begin
                    if (cfg_acc) begin
                        if (i_cfg_index == REG_START) r_start <= i_cfg_data;
                        else if (i_cfg_index == REG_ZONE) r_zone_frames <= i_cfg_data[CNT_W-1:0];
                        r_cnt <= '0;
                        for (int k = 0; k < NORD; k++) begin
                            r_head[k] <= LINK_NONE;
                            r_tail[k] <= LINK_NONE;
                        end
                    end else if (in_acc) begin
                        r_op    <= s_tuser;
                        r_count <= s_tdata[12:0];
                        r_pfn   <= s_tdata[32:13];
                    end
                end
                S_DEC: begin
                    r_gpfn   <= '0;
                    r_gfr    <= '0;
                    r_status <= ST_OK;
                    r_ord    <= dec_ord;
                    r_oi     <= dec_ord;
                    r_idx    <= dec_idx[IDX_W-1:0];
                    if (dec_big) r_status <= (r_op == OP_ALLOC) ? ST_TOO_BIG : ST_BAD;
                    else if (r_op == OP_FREE && dec_bad) r_status <= ST_BAD;
                end
                S_ASRCH: begin
                    if (r_head[r_oi] != LINK_NONE) begin
                        r_idx  <= r_head[r_oi][IDX_W-1:0];
                        r_bidx <= r_head[r_oi][IDX_W-1:0];
                    end else if (r_oi == ORD_TOP) begin
                        r_status <= ST_NO_FREE;
                    end else begin
                        r_oi <= r_oi + ORD_W'(1);
                    end
                end
                S_ULRD: begin
                    r_p    <= r_rd.prev;
                    r_n    <= r_rd.next;
                    r_uord <= r_rd.ord;
                end
                S_U1: begin
                    if (!ul_skip && r_p == LINK_NONE && r_head[r_uord] == {1'b0, r_bidx})
                        r_head[r_uord] <= r_n;
                    if (ul_skip && r_op == OP_FREE) begin
                        r_idx <= r_idx & ~bsz[IDX_W-1:0];
                        r_ord <= r_ord + ORD_W'(1);
                    end
                end
                S_U2: begin
                    if (r_n == LINK_NONE && r_tail[r_uord] == {1'b0, r_bidx})
                        r_tail[r_uord] <= r_p;
                end
                S_U3: begin
                    if (r_op == OP_FREE) begin
                        r_idx <= r_idx & ~bsz[IDX_W-1:0];
                        r_ord <= r_ord + ORD_W'(1);
                    end
                end
                S_SPLIT: begin
                    if (r_oi > r_ord) begin
                        r_oi     <= r_oi - ORD_W'(1);
                        r_lh_ord <= r_oi - ORD_W'(1);
                        r_lh_idx <= r_idx + (IDX_W'(1) << (r_oi - ORD_W'(1)));
                    end else begin
                        r_gpfn <= r_start + PFN_W'(r_idx);
                        r_gfr  <= GFR_W'(bsz);
                    end
                end
                S_LH1: r_h <= r_head[r_lh_ord];
                S_LH2: begin
                    if (r_h == LINK_NONE) r_tail[r_lh_ord] <= {1'b0, r_lh_idx};
                    r_head[r_lh_ord] <= {1'b0, r_lh_idx};
                end
                S_FCHK: if (r_rd.free) r_status <= ST_BAD;
                S_M0: begin
                    r_bidx <= buddy[IDX_W-1:0];
                    if (!m0_ok) begin
                        r_lh_idx <= r_idx;
                        r_lh_ord <= r_ord;
                    end
                end
                S_M1: begin
                    r_p    <= r_rd.prev;
                    r_n    <= r_rd.next;
                    r_uord <= r_rd.ord;
                    if (!m1_ok) begin
                        r_lh_idx <= r_idx;
                        r_lh_ord <= r_ord;
                    end
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule
